// File: sv/rrs_pkg.sv
// Shared types and constants for the read-range set table.
// Request/result payload structs, table entry layout and scan rule codes.
// No dependencies.
package rrs_pkg;

  localparam int MAX_RANGES_DEF = 64;
  localparam int WORD_W         = 32;

  typedef struct packed {
    logic              operation;
    logic [WORD_W-1:0] first_article;
    logic [WORD_W-1:0] last_article;
  } rrs_req_t;

  typedef struct packed {
    logic              article_was_read;
    logic [WORD_W-1:0] highest_read;
    logic [WORD_W-1:0] articles_read;
    logic              table_full;
  } rrs_res_t;

  localparam logic OP_MARK  = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  typedef struct packed {
    logic [WORD_W-1:0] hi;
    logic [WORD_W-1:0] lo;
  } rrs_entry_t;

  typedef enum logic [1:0] {
    RULE_NONE,
    RULE_INSIDE,
    RULE_UPDATE,
    RULE_INSERT
  } rrs_kind_t;

  typedef struct packed {
    rrs_kind_t         kind;
    logic [WORD_W-1:0] new_lo;
    logic [WORD_W-1:0] new_hi;
    logic              point_hit;
  } rrs_rule_t;

endpackage

// File: sv/rrs_mem.sv
// Simple dual-port table memory: one write port, one read port, registered read.
// Depends on rrs_pkg for the entry layout.
module rrs_mem #(
  parameter int DEPTH = rrs_pkg::MAX_RANGES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  rrs_pkg::rrs_entry_t      wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output rrs_pkg::rrs_entry_t      rdata
);
  import rrs_pkg::*;

  rrs_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/rrs_rule.sv
// Rule decision for one stored range against the request's range.
// Pure logic; depends on rrs_pkg for the entry and rule types.
module rrs_rule (
  input  logic [rrs_pkg::WORD_W-1:0] lo,
  input  logic [rrs_pkg::WORD_W-1:0] hi,
  input  rrs_pkg::rrs_entry_t        entry,
  output rrs_pkg::rrs_rule_t         rule
);
  import rrs_pkg::*;

  logic [WORD_W-1:0] rs;
  logic [WORD_W-1:0] re;

  assign rs = entry.lo;
  assign re = entry.hi;

  always_comb begin
    rule.kind      = RULE_NONE;
    rule.new_lo    = rs;
    rule.new_hi    = re;
    rule.point_hit = (lo >= rs) && (lo <= re);
    // first matching rule wins, in scan priority order
    if ((lo >= rs) && (hi <= re)) begin
      rule.kind = RULE_INSIDE;
    end else if ((lo <= rs) && (hi >= rs)) begin
      rule.kind   = RULE_UPDATE;
      rule.new_lo = lo;
      rule.new_hi = (hi > re) ? hi : re;
    end else if ((hi >= re) && (lo >= rs) && (lo <= re)) begin
      rule.kind   = RULE_UPDATE;
      rule.new_hi = hi;
    end else if ((re != '1) && (lo == re + WORD_W'(1))) begin
      rule.kind   = RULE_UPDATE;
      rule.new_hi = hi;
    end else if ((rs != '0) && (hi == rs - WORD_W'(1))) begin
      rule.kind   = RULE_UPDATE;
      rule.new_lo = lo;
    end else if ((lo < rs) && (hi < rs)) begin
      rule.kind = RULE_INSERT;
    end
  end

endmodule

// File: sv/read_range_set_table_core.sv
// Read-range set table: ordered list of inclusive ranges held in one table memory.
// Depends on rrs_pkg, rrs_mem and rrs_rule.
//
//   port      dir  payload     handshake
//   start     in   req         taken when start & !busy
//   done      out  res         one-cycle strobe, no back-pressure
//
// One request at a time. A request scans the stored entries in order (one memory read per
// cycle, pipelined), then writes back an update or a new range, and for an insert first
// shifts the m entries from the insert point up by one place; an empty table skips the
// scan. Worst case is an insert into a table one short of full, set by the single read
// port. Reset clears the fill count, the running length sum and the last-end register;
// table contents are never read before written. The result is shown for one cycle while
// busy is low again.
module read_range_set_table_core #(
  parameter int MAX_RANGES = rrs_pkg::MAX_RANGES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  rrs_pkg::rrs_req_t req,
  output logic              busy,
  output logic              done,
  output rrs_pkg::rrs_res_t res
);
  import rrs_pkg::*;

  localparam int IDX_W = $clog2(MAX_RANGES);
  localparam int CNT_W = $clog2(MAX_RANGES + 1);
  localparam int SUM_W = IDX_W + WORD_W + 1;
  localparam int LEN_W = WORD_W + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_SHIFT,
    S_PLACE,
    S_FINISH
  } state_t;

  state_t            state;
  logic              op;
  logic [WORD_W-1:0] lo;
  logic [WORD_W-1:0] hi;
  logic [CNT_W-1:0]  used;
  logic [SUM_W-1:0]  total;
  logic [WORD_W-1:0] last_hi;
  logic              found;
  logic              dropped;

  // scan pipeline
  logic [CNT_W-1:0]  idx;
  logic              pv;
  logic [IDX_W-1:0]  eidx;

  // pending update
  logic [IDX_W-1:0]  upd_idx;
  logic [WORD_W-1:0] upd_lo;
  logic [WORD_W-1:0] upd_hi;
  logic [LEN_W-1:0]  old_len;

  // shift pipeline
  logic [IDX_W-1:0]  pos;
  logic [IDX_W-1:0]  sj;
  logic [IDX_W-1:0]  srd;
  logic              sh_issue;
  logic              sv;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  rrs_entry_t        mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;
  rrs_entry_t        mem_rdata;
  rrs_rule_t         rule;

  logic              full;
  logic              eval_last;
  logic [LEN_W-1:0]  entry_len;
  logic [LEN_W-1:0]  upd_len;
  logic [LEN_W-1:0]  new_len;
  logic [WORD_W-1:0] req_lo;
  logic [WORD_W-1:0] req_hi;

  rrs_mem #(
    .DEPTH (MAX_RANGES)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rrs_rule u_rule (
    .lo    (lo),
    .hi    (hi),
    .entry (mem_rdata),
    .rule  (rule)
  );

  assign busy      = (state != S_IDLE);
  assign full      = (used == CNT_W'(MAX_RANGES));
  assign eval_last = ((CNT_W'(eidx) + CNT_W'(1)) == used);
  assign entry_len = LEN_W'(mem_rdata.hi) - LEN_W'(mem_rdata.lo) + LEN_W'(1);
  assign upd_len   = LEN_W'(upd_hi) - LEN_W'(upd_lo) + LEN_W'(1);
  assign new_len   = LEN_W'(hi) - LEN_W'(lo) + LEN_W'(1);

  // a mark with a reversed pair is taken as last..first
  always_comb begin
    req_lo = req.first_article;
    req_hi = req.last_article;
    if ((req.operation == OP_MARK) && (req.first_article > req.last_article)) begin
      req_lo = req.last_article;
      req_hi = req.first_article;
    end
  end

  always_comb begin
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '{hi: hi, lo: lo};
    unique case (state)
      S_SCAN: begin
        mem_raddr = idx[IDX_W-1:0];
      end
      S_SHIFT: begin
        mem_raddr = sj;
        if (sv) begin
          mem_we    = 1'b1;
          mem_waddr = srd + IDX_W'(1);
          mem_wdata = mem_rdata;
        end
      end
      S_APPLY: begin
        mem_we    = 1'b1;
        mem_waddr = upd_idx;
        mem_wdata = '{hi: upd_hi, lo: upd_lo};
      end
      S_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = pos;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      used     <= '0;
      total    <= '0;
      last_hi  <= '0;
      done     <= 1'b0;
      pv       <= 1'b0;
      sv       <= 1'b0;
      sh_issue <= 1'b0;
      found    <= 1'b0;
      dropped  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op      <= req.operation;
            lo      <= req_lo;
            hi      <= req_hi;
            found   <= 1'b0;
            dropped <= 1'b0;
            idx     <= '0;
            pv      <= 1'b0;
            if (used == '0) begin
              pos <= '0;
              state <= (req.operation == OP_CHECK) ? S_FINISH : S_PLACE;
            end else begin
              state <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          if (idx < used) begin
            pv   <= 1'b1;
            eidx <= idx[IDX_W-1:0];
            idx  <= idx + CNT_W'(1);
          end else begin
            pv <= 1'b0;
          end
          if (pv) begin
            if (op == OP_CHECK) begin
              if (rule.point_hit) begin
                found <= 1'b1;
                state <= S_FINISH;
              end else if (eval_last) begin
                state <= S_FINISH;
              end
            end else begin
              case (rule.kind)
                RULE_INSIDE: begin
                  state <= S_FINISH;
                end
                RULE_UPDATE: begin
                  upd_idx <= eidx;
                  upd_lo  <= rule.new_lo;
                  upd_hi  <= rule.new_hi;
                  old_len <= entry_len;
                  state   <= S_APPLY;
                end
                RULE_INSERT: begin
                  if (full) begin
                    dropped <= 1'b1;
                    state   <= S_FINISH;
                  end else begin
                    pos      <= eidx;
                    sj       <= IDX_W'(used - CNT_W'(1));
                    sh_issue <= 1'b1;
                    sv       <= 1'b0;
                    state    <= S_SHIFT;
                  end
                end
                default: begin
                  if (eval_last) begin
                    if (full) begin
                      dropped <= 1'b1;
                      state   <= S_FINISH;
                    end else begin
                      // append after the last entry, nothing to move
                      pos   <= IDX_W'(used);
                      state <= S_PLACE;
                    end
                  end
                end
              endcase
            end
          end
        end

        S_APPLY: begin
          total <= total + SUM_W'(upd_len) - SUM_W'(old_len);
          if ((CNT_W'(upd_idx) + CNT_W'(1)) == used) begin
            last_hi <= upd_hi;
          end
          state <= S_FINISH;
        end

        S_SHIFT: begin
          // read j-1 while the previous read, of j, is written to j+1
          if (sh_issue) begin
            sv  <= 1'b1;
            srd <= sj;
            if (sj == pos) begin
              sh_issue <= 1'b0;
            end else begin
              sj <= sj - IDX_W'(1);
            end
          end else begin
            sv <= 1'b0;
            if (!sv) begin
              state <= S_PLACE;
            end
          end
        end

        S_PLACE: begin
          used  <= used + CNT_W'(1);
          total <= total + SUM_W'(new_len);
          if (CNT_W'(pos) == used) begin
            last_hi <= hi;
          end
          state <= S_FINISH;
        end

        S_FINISH: begin
          done                 <= 1'b1;
          res.article_was_read <= found;
          res.highest_read     <= last_hi;
          res.articles_read    <= (|total[SUM_W-1:WORD_W]) ? '1 : total[WORD_W-1:0];
          res.table_full       <= dropped;
          state                <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
